// ===== design/hjbh_pkg.sv =====
// Shared constants, types and codes for the hash join bucket head insert block.
package hjbh_pkg;

   localparam int MAX_DEGREE = 16;
   localparam int TAG_BITS   = 16;
   localparam int ADDR_W     = 48;
   localparam int HASH_W     = 64;
   localparam int HEAD_W     = 64;
   localparam int TAG_SHIFT  = HEAD_W - TAG_BITS;
   localparam int BKT_W      = MAX_DEGREE;
   localparam int DEPTH      = 1 << MAX_DEGREE;
   localparam int WIDTH_W    = 7;
   localparam int DEG_W      = 5;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = ADDR_W + HASH_W;
   localparam int RSP_DATA_W = BKT_W + ADDR_W + ADDR_W;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_HASH_BYTES    = 3'd0;
   localparam csr_idx_type CSR_TABLE_DEGREE  = 3'd1;
   localparam csr_idx_type CSR_TAG_ENABLE    = 3'd2;
   localparam csr_idx_type CSR_TAG_HASH_MASK = 3'd3;
   localparam csr_idx_type CSR_LINK_OFFSET   = 3'd4;

   typedef struct packed {
      logic [3:0]  hash_bytes;
      logic [4:0]  table_degree;
      logic        tag_enable;
      logic [15:0] tag_hash_mask;
      logic [15:0] link_offset;
   } cfg_type;

   typedef struct packed {
      logic              we;
      logic [BKT_W-1:0]  addr;
      logic [HEAD_W-1:0] data;
   } mem_wr_type;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } ins_state_type;

endpackage

// ===== design/hjbh_head_mem.sv =====
// Bucket head memory: one write port, one read port with registered read data.
module hjbh_head_mem (
   input  logic                         clock,
   input  hjbh_pkg::mem_wr_type         wr,
   input  logic                         rd_en,
   input  logic [hjbh_pkg::BKT_W-1:0]   rd_addr,
   output logic [hjbh_pkg::HEAD_W-1:0]  rd_data
);
   import hjbh_pkg::*;

   logic [HEAD_W-1:0] head_mem [DEPTH];
   logic [HEAD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         head_mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= head_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/hjbh_clear_seq.sv =====
// Post-reset sweep that writes a null head into every bucket.
module hjbh_clear_seq (
   input  logic                  clock,
   input  logic                  reset,
   output logic                  clr_busy,
   output hjbh_pkg::mem_wr_type  clr_wr
);
   import hjbh_pkg::*;

   logic [BKT_W-1:0] clr_addr_ff, clr_addr_in;
   logic             clr_busy_ff, clr_busy_in;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (&clr_addr_ff) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   assign clr_busy    = clr_busy_ff;
   assign clr_wr.we   = clr_busy_ff;
   assign clr_wr.addr = clr_addr_ff;
   assign clr_wr.data = '0;

endmodule

// ===== design/hjbh_insert.sv =====
// Bucket select, head read-modify-write sequencer and result register.
module hjbh_insert (
   input  logic                             clock,
   input  logic                             reset,
   input  hjbh_pkg::cfg_type                cfg,
   input  logic                             clr_busy,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [hjbh_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [hjbh_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tuser,
   output logic                             rd_en,
   output logic [hjbh_pkg::BKT_W-1:0]       rd_addr,
   input  logic [hjbh_pkg::HEAD_W-1:0]      rd_data,
   output hjbh_pkg::mem_wr_type             ins_wr
);
   import hjbh_pkg::*;

   ins_state_type state_ff, state_in;

   logic [ADDR_W-1:0]     row_ff;
   logic [HASH_W-1:0]     hash_ff;
   logic [BKT_W-1:0]      bucket_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_user_ff;

   logic [3:0]          hb_eff;
   logic [WIDTH_W-1:0]  hwidth;
   logic [DEG_W-1:0]    deg;
   logic [WIDTH_W-1:0]  shamt;
   logic [HASH_W-1:0]   hash_in;
   logic [HASH_W-1:0]   hash_cut;
   logic [HASH_W-1:0]   bucket_wide;
   logic                accept;
   logic                load;

   logic [TAG_BITS-1:0] tag_new;
   logic [HEAD_W-1:0]   new_head;
   logic [HEAD_W-1:0]   link_word;
   logic [ADDR_W-1:0]   link_addr;

   // bucket = top deg bits of the hash cut to the hash width
   always_comb begin
      priority if (cfg.hash_bytes == 4'd0) begin
         hb_eff = 4'd1;
      end else if (cfg.hash_bytes > 4'd8) begin
         hb_eff = 4'd8;
      end else begin
         hb_eff = cfg.hash_bytes;
      end
      hwidth = {hb_eff, 3'b000};
      if ({2'b00, cfg.table_degree} > hwidth) begin
         deg = hwidth[DEG_W-1:0];
      end else begin
         deg = cfg.table_degree;
      end
      if (deg > DEG_W'(MAX_DEGREE)) begin
         deg = DEG_W'(MAX_DEGREE);
      end
      shamt       = hwidth - {2'b00, deg};
      hash_in     = req_tdata[REQ_DATA_W-1:ADDR_W];
      hash_cut    = hash_in & ((HASH_W'(1) << hwidth) - HASH_W'(1));
      bucket_wide = hash_cut >> shamt;
   end

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE) && !clr_busy;
   assign rd_en      = accept;
   assign rd_addr    = bucket_wide[BKT_W-1:0];

   always_comb begin
      tag_new = (hash_ff[TAG_BITS-1:0] & cfg.tag_hash_mask[TAG_BITS-1:0])
              | rd_data[HEAD_W-1:TAG_SHIFT];
      if (cfg.tag_enable) begin
         new_head  = {tag_new, row_ff};
         link_word = {{TAG_BITS{1'b0}}, rd_data[TAG_SHIFT-1:0]};
      end else begin
         new_head  = {{(HEAD_W-ADDR_W){1'b0}}, row_ff};
         link_word = rd_data;
      end
      link_addr = row_ff + {{(ADDR_W-16){1'b0}}, cfg.link_offset};
   end

   always_comb begin
      state_in     = state_ff;
      load         = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load         = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         row_ff    <= req_tdata[ADDR_W-1:0];
         hash_ff   <= hash_cut;
         bucket_ff <= bucket_wide[BKT_W-1:0];
      end
      if (load) begin
         rsp_data_ff <= {link_word[ADDR_W-1:0], link_addr, bucket_ff};
         rsp_user_ff <= |link_word;
      end
   end

   assign ins_wr.we   = load;
   assign ins_wr.addr = bucket_ff;
   assign ins_wr.data = new_head;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== design/hash_join_bucket_head_insert.sv =====
// Top level of the hash join build-side bucket head insert block.
// Each item is read, then updated: the bucket head is read from the single-port-pair
// head memory when the item is accepted, and the updated head is written back,
// with the result loaded into the output register, once that register is free or
// being taken. The next item is accepted once the write-back has happened, also
// while that result still waits to be taken. After reset the head memory is swept
// to null heads, one bucket per cycle; no item is accepted during that sweep, while
// configuration writes are taken.
module hash_join_bucket_head_insert (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [hjbh_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hjbh_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // row_address[47:0], hash_value[111:48]
   input  logic [hjbh_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // bucket_index[15:0], link_address[63:16], link_pointer[111:64]
   output logic [hjbh_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // link_valid[0]
   output logic                             rsp_tuser
);
   import hjbh_pkg::*;

   cfg_type            cfg_ff;
   logic               clr_busy;
   mem_wr_type         clr_wr;
   mem_wr_type         ins_wr;
   mem_wr_type         mem_wr;
   logic               rd_en;
   logic [BKT_W-1:0]   rd_addr;
   logic [HEAD_W-1:0]  rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hash_bytes    <= 4'd4;
         cfg_ff.table_degree  <= 5'd16;
         cfg_ff.tag_enable    <= 1'b0;
         cfg_ff.tag_hash_mask <= 16'hFFFF;
         cfg_ff.link_offset   <= 16'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HASH_BYTES:    cfg_ff.hash_bytes    <= csr_wdata[3:0];
            CSR_TABLE_DEGREE:  cfg_ff.table_degree  <= csr_wdata[4:0];
            CSR_TAG_ENABLE:    cfg_ff.tag_enable    <= csr_wdata[0];
            CSR_TAG_HASH_MASK: cfg_ff.tag_hash_mask <= csr_wdata;
            CSR_LINK_OFFSET:   cfg_ff.link_offset   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign mem_wr = clr_busy ? clr_wr : ins_wr;

   hjbh_clear_seq u_clear (
      .clock    (clock),
      .reset    (reset),
      .clr_busy (clr_busy),
      .clr_wr   (clr_wr)
   );

   hjbh_head_mem u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   hjbh_insert u_insert (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .clr_busy   (clr_busy),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .ins_wr     (ins_wr)
   );

endmodule

// ===== design/hjbh_checker.sv =====
// Port-level checks for the bucket head insert block, bound to the top level.
module hjbh_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [hjbh_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             rsp_tuser
);
   import hjbh_pkg::*;

   // stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

   // one read-modify-write in flight
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted during head update");

   a_rsp_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result without an item in flight");

   // clearing sweep starts right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_tready)
      else $error("item taken before head memory sweep");

endmodule

bind hash_join_bucket_head_insert hjbh_checker u_hjbh_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== bench/tb_hash_join_bucket_head_insert.sv =====
// Self-checking testbench for the hash join bucket head insert block.
`timescale 1ns / 100ps

module tb_hash_join_bucket_head_insert;
   import hjbh_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int N_PHASES    = 14;
   localparam int PHASE_ITEMS = 100;
   localparam int DIR_ROWS    = 35;

   typedef struct packed {
      logic [BKT_W-1:0]  bucket_index;
      logic [ADDR_W-1:0] link_address;
      logic [ADDR_W-1:0] link_pointer;
      logic              link_valid;
   } link_rec_type;

   typedef enum logic {
      ROW_CSR,
      ROW_INSERT
   } row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      csr_idx_type       idx;
      logic [15:0]       val;
      logic [ADDR_W-1:0] addr;
      logic [HASH_W-1:0] hash;
      logic              typed;
      link_rec_type      want;
   } dir_row_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index  = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tuser;

   cfg_type                 shadow_cfg;
   logic [HEAD_W-1:0]       head_mem [DEPTH];
   link_rec_type            pending_links [$];

   int                      cycle_count   = 0;
   int                      err_count     = 0;
   int                      items_sent    = 0;
   int                      links_checked = 0;
   int                      chained_count = 0;
   int                      csr_writes    = 0;
   int                      stall_pct     = 0;
   int                      stall_left    = 0;

   // directed rows; expectations typed in only where obvious, else predicted
   dir_row_type dir_tab [DIR_ROWS] = '{
      '{ROW_INSERT, CSR_HASH_BYTES, 16'h0, 48'h1000, 64'h1234_5678_9ABC_DEF0,
        1'b1, '{16'h9ABC, 48'h1000, 48'h0, 1'b0}},
      '{ROW_INSERT, CSR_HASH_BYTES, 16'h0, 48'h2000, 64'h1234_5678_9ABC_DEF0,
        1'b1, '{16'h9ABC, 48'h2000, 48'h1000, 1'b1}},
      '{ROW_INSERT, CSR_HASH_BYTES, 16'h0, 48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
        1'b1, '{16'hFFFF, 48'hFFFF_FFFF_FFFF, 48'h0, 1'b0}},
      '{ROW_INSERT, CSR_HASH_BYTES, 16'h0, 48'h0, 64'h0,
        1'b1, '{16'h0, 48'h0, 48'h0, 1'b0}},
      '{ROW_INSERT, CSR_HASH_BYTES, 16'h0, 48'h1, 64'h0,
        1'b1, '{16'h0, 48'h1, 48'h0, 1'b0}},
      '{ROW_CSR, CSR_LINK_OFFSET, 16'hFFFF, 48'h0, 64'h0, 1'b0, '0},
      '{ROW_INSERT, CSR_HASH_BYTES, 16'h0, 48'hFFFF_FFFF_FFFF, 64'h0000_0001_0000_0000,
        1'b1, '{16'h0, 48'h0000_0000_FFFE, 48'h1, 1'b1}},
      '{ROW_CSR, CSR_HASH_BYTES, 16'd8, 48'h0, 64'h0, 1'b0, '0},
      '{ROW_CSR, CSR_TABLE_DEGREE, 16'd0, 48'h0, 64'h0, 1'b0, '0},
      '{ROW_CSR, CSR_TAG_ENABLE, 16'd1, 48'h0, 64'h0, 1'b0, '0},
      '{ROW_INSERT, CSR_HASH_BYTES, 16'h0, 48'h40, 64'hFFFF_FFFF_FFFF_FFFF,
        1'b1, '{16'h0, 48'h1_003F, 48'hFFFF_FFFF_FFFF, 1'b1}},
      '{ROW_INSERT, CSR_HASH_BYTES, 16'h0, 48'h0, 64'h0,
        1'b1, '{16'h0, 48'hFFFF, 48'h40, 1'b1}},
      '{ROW_INSERT, CSR_HASH_BYTES, 16'h0, 48'h80, 64'h0,
        1'b1, '{16'h0, 48'h1_007F, 48'h0, 1'b0}},
      '{ROW_CSR, CSR_TAG_ENABLE, 16'd0, 48'h0, 64'h0, 1'b0, '0},
      '{ROW_INSERT, CSR_HASH_BYTES, 16'h0, 48'hC0, 64'h0,
        1'b1, '{16'h0, 48'h1_00BF, 48'h80, 1'b1}},
      '{ROW_CSR, CSR_HASH_BYTES, 16'd2, 48'h0, 64'h0, 1'b0, '0},
      '{ROW_CSR, CSR_TABLE_DEGREE, 16'd16, 48'h0, 64'h0, 1'b0, '0},
      '{ROW_CSR, CSR_TAG_ENABLE, 16'd1, 48'h0, 64'h0, 1'b0, '0},
      '{ROW_CSR, CSR_TAG_HASH_MASK, 16'h00F0, 48'h0, 64'h0, 1'b0, '0},
      '{ROW_CSR, CSR_LINK_OFFSET, 16'h0, 48'h0, 64'h0, 1'b0, '0},
      '{ROW_INSERT, CSR_HASH_BYTES, 16'h0, 48'h0, 64'h1234, 1'b0, '0},
      '{ROW_CSR, CSR_TAG_ENABLE, 16'd0, 48'h0, 64'h0, 1'b0, '0},
      '{ROW_INSERT, CSR_HASH_BYTES, 16'h0, 48'h5, 64'h1234,
        1'b1, '{16'h1234, 48'h5, 48'h0, 1'b1}},
      '{ROW_CSR, CSR_HASH_BYTES, 16'd0, 48'h0, 64'h0, 1'b0, '0},
      '{ROW_CSR, CSR_TABLE_DEGREE, 16'd31, 48'h0, 64'h0, 1'b0, '0},
      '{ROW_INSERT, CSR_HASH_BYTES, 16'h0, 48'h100, 64'hFFFF_FFFF_FFFF_FFA5, 1'b0, '0},
      '{ROW_CSR, CSR_HASH_BYTES, 16'd15, 48'h0, 64'h0, 1'b0, '0},
      '{ROW_CSR, CSR_TABLE_DEGREE, 16'd20, 48'h0, 64'h0, 1'b0, '0},
      '{ROW_INSERT, CSR_HASH_BYTES, 16'h0, 48'h200, 64'hDEAD_0000_0000_0001, 1'b0, '0},
      '{ROW_CSR, CSR_HASH_BYTES, 16'd3, 48'h0, 64'h0, 1'b0, '0},
      '{ROW_CSR, CSR_TABLE_DEGREE, 16'd12, 48'h0, 64'h0, 1'b0, '0},
      '{ROW_INSERT, CSR_HASH_BYTES, 16'h0, 48'h300, 64'h00AB_CDEF, 1'b0, '0},
      '{ROW_CSR, CSR_HASH_BYTES, 16'd1, 48'h0, 64'h0, 1'b0, '0},
      '{ROW_CSR, CSR_TABLE_DEGREE, 16'd1, 48'h0, 64'h0, 1'b0, '0},
      '{ROW_INSERT, CSR_HASH_BYTES, 16'h0, 48'h400, 64'h80, 1'b0, '0}
   };

   hash_join_bucket_head_insert i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic int hash_bits();
      if (shadow_cfg.hash_bytes == 4'd0) return 8;
      if (shadow_cfg.hash_bytes > 4'd8) return 64;
      return 8 * int'(shadow_cfg.hash_bytes);
   endfunction

   function automatic int bucket_bits(input int w);
      int d;
      d = int'(shadow_cfg.table_degree);
      if (d > w) d = w;
      if (d > MAX_DEGREE) d = MAX_DEGREE;
      return d;
   endfunction

   // swap the row into its bucket head and return the link the host must write
   function automatic link_rec_type insert_head(input logic [ADDR_W-1:0] addr,
                                                input logic [HASH_W-1:0] hash);
      int                w;
      int                d;
      logic [HASH_W-1:0] h;
      logic [HASH_W-1:0] bkt;
      logic [HEAD_W-1:0] prev_head;
      logic [HEAD_W-1:0] link;
      logic [HEAD_W-1:0] tag;
      link_rec_type      rec;
      w = hash_bits();
      d = bucket_bits(w);
      h = hash;
      if (w < 64) h = hash & ((64'd1 << w) - 64'd1);
      bkt = (d > 0) ? (h >> (w - d)) : 64'd0;
      prev_head = head_mem[bkt[BKT_W-1:0]];
      if (shadow_cfg.tag_enable) begin
         tag = (h & 64'(shadow_cfg.tag_hash_mask)) | (prev_head >> TAG_SHIFT);
         tag = tag & ((64'd1 << TAG_BITS) - 64'd1);
         head_mem[bkt[BKT_W-1:0]] = (tag << TAG_SHIFT) | 64'(addr);
         link = prev_head & ((64'd1 << TAG_SHIFT) - 64'd1);
      end else begin
         head_mem[bkt[BKT_W-1:0]] = 64'(addr);
         link = prev_head;
      end
      rec.bucket_index = bkt[BKT_W-1:0];
      rec.link_address = addr + ADDR_W'(shadow_cfg.link_offset);
      rec.link_pointer = link[ADDR_W-1:0];
      rec.link_valid   = (link != '0);
      return rec;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      err_count++;
      $display("mismatch on %s at result %0d: got %h, expected %h",
               what, links_checked, got, want);
   endtask

   task automatic csr_write(input csr_idx_type idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_HASH_BYTES:    shadow_cfg.hash_bytes    = val[3:0];
         CSR_TABLE_DEGREE:  shadow_cfg.table_degree  = val[4:0];
         CSR_TAG_ENABLE:    shadow_cfg.tag_enable    = val[0];
         CSR_TAG_HASH_MASK: shadow_cfg.tag_hash_mask = val;
         CSR_LINK_OFFSET:   shadow_cfg.link_offset   = val;
         default: ;
      endcase
      csr_writes++;
   endtask

   // leaves tvalid high; the caller either sends the next item or lowers it
   task automatic push_item(input logic [ADDR_W-1:0] addr, input logic [HASH_W-1:0] hash,
                            input logic typed, input link_rec_type typed_rec);
      link_rec_type pred;
      req_tdata  <= {hash, addr};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pred = insert_head(addr, hash);
      pending_links.push_back(typed ? typed_rec : pred);
      items_sent++;
   endtask

   task automatic idle_for(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_links();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_links.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(1, 100) <= stall_pct) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 20);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : chk_results
      link_rec_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_links.size() == 0) begin
            report_mismatch("result with no item", 64'(rsp_tdata[BKT_W-1:0]), 64'd0);
         end else begin
            want = pending_links.pop_front();
            if (rsp_tdata[BKT_W-1:0] != want.bucket_index)
               report_mismatch("bucket_index", 64'(rsp_tdata[BKT_W-1:0]),
                               64'(want.bucket_index));
            if (rsp_tdata[BKT_W +: ADDR_W] != want.link_address)
               report_mismatch("link_address", 64'(rsp_tdata[BKT_W +: ADDR_W]),
                               64'(want.link_address));
            if (rsp_tdata[BKT_W+ADDR_W +: ADDR_W] != want.link_pointer)
               report_mismatch("link_pointer", 64'(rsp_tdata[BKT_W+ADDR_W +: ADDR_W]),
                               64'(want.link_pointer));
            if (rsp_tuser != want.link_valid)
               report_mismatch("link_valid", 64'(rsp_tuser), 64'(want.link_valid));
            if (want.link_valid) chained_count++;
            links_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_links.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int                ph;
      int                n;
      int                k;
      int                blen;
      int                w;
      int                d;
      bit                prev_ins;
      bit                quiet;
      logic [3:0]        hb;
      logic [4:0]        deg;
      logic              ten;
      logic [15:0]       tmask;
      logic [15:0]       loff;
      logic [ADDR_W-1:0] addr;
      logic [HASH_W-1:0] hash;
      logic [HASH_W-1:0] field;
      logic [HASH_W-1:0] hot_hash [8];

      foreach (head_mem[j]) head_mem[j] = '0;
      shadow_cfg = '{hash_bytes: 4'd4, table_degree: 5'd16, tag_enable: 1'b0,
                     tag_hash_mask: 16'hFFFF, link_offset: 16'h0};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      prev_ins = 1'b0;
      foreach (dir_tab[i]) begin
         if (dir_tab[i].kind == ROW_CSR) begin
            if (prev_ins) drain_links();
            csr_write(dir_tab[i].idx, dir_tab[i].val);
            prev_ins = 1'b0;
         end else begin
            csr_we <= 1'b0;
            push_item(dir_tab[i].addr, dir_tab[i].hash, dir_tab[i].typed, dir_tab[i].want);
            prev_ins = 1'b1;
         end
      end

      for (ph = 0; ph < N_PHASES; ph++) begin
         drain_links();
         if (ph == 0) begin
            hb = 4'd1; deg = 5'd0; ten = 1'b0; tmask = 16'h0; loff = 16'h0;
         end else if (ph == 1) begin
            hb = 4'd8; deg = 5'd31; ten = 1'b1; tmask = 16'hFFFF; loff = 16'hFFFF;
         end else begin
            hb  = ($urandom_range(0, 4) != 0) ? 4'(1 << $urandom_range(0, 3))
                                              : 4'($urandom_range(0, 15));
            deg = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(17, 31))
                                              : 5'($urandom_range(0, 16));
            ten = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
               0: tmask = 16'h0;
               1: tmask = 16'hFFFF;
               default: tmask = 16'($urandom);
            endcase
            case ($urandom_range(0, 3))
               0: loff = 16'h0;
               1: loff = 16'hFFFF;
               default: loff = 16'($urandom);
            endcase
         end
         csr_write(CSR_HASH_BYTES, 16'(hb));
         csr_write(CSR_TABLE_DEGREE, 16'(deg));
         csr_write(CSR_TAG_ENABLE, 16'(ten));
         csr_write(CSR_TAG_HASH_MASK, tmask);
         csr_write(CSR_LINK_OFFSET, loff);
         csr_we <= 1'b0;

         // hot hashes share bucket bits so chains build up
         w = hash_bits();
         d = bucket_bits(w);
         field = (d > 0) ? (((64'd1 << d) - 64'd1) << (w - d)) : 64'd0;
         foreach (hot_hash[j]) hot_hash[j] = {$urandom, $urandom};
         quiet = (ph % 4 == 3);
         stall_pct = quiet ? 0 : 10 * $urandom_range(1, 6);

         n = 0;
         while (n < PHASE_ITEMS) begin
            blen = $urandom_range(1, 24);
            for (k = 0; k < blen && n < PHASE_ITEMS; k++) begin
               case ($urandom_range(0, 19))
                  0: addr = '0;
                  1: addr = '1;
                  default: addr = ADDR_W'({$urandom, $urandom});
               endcase
               hash = {$urandom, $urandom};
               if ($urandom_range(0, 3) != 0)
                  hash = (hot_hash[$urandom_range(0, 7)] & field) | (hash & ~field);
               push_item(addr, hash, 1'b0, '0);
               n++;
               if (ph == 7 && n == PHASE_ITEMS / 2) drain_links();
            end
            if (!quiet && $urandom_range(0, 3) != 0) idle_for($urandom_range(1, 12));
         end
      end

      drain_links();
      repeat (8) @(posedge clock);
      $display("%0d rows inserted over %0d table settings with %0d register writes",
               items_sent, N_PHASES + 1, csr_writes);
      $display("%0d results checked, %0d carried a chain link, %0d mismatches",
               links_checked, chained_count, err_count);
      if (err_count == 0 && pending_links.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
